[hdl/swa_pkg.sv]
// Package with the shared constants, types and helper functions of the stylus window averager.
`default_nettype none

package swa_pkg;

  // Ring depth and stored coordinate width.
  localparam int RING_SLOTS = 8;
  localparam int COORD_BITS = 12;

  // Derived widths.
  localparam int IDX_W    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W    = $clog2(RING_SLOTS + 1);
  localparam int SUM_W    = COORD_BITS + CNT_W;
  localparam int DCNT_W   = $clog2(SUM_W + 1);
  localparam int AGE_W    = 16;
  localparam int WIN_W    = 16;
  localparam int OUT_W    = 12;
  localparam int USED_W   = 4;

  localparam logic [AGE_W-1:0]  AgeMax     = '1;
  localparam logic [WIN_W-1:0]  WindowInit = WIN_W'(100);
  localparam logic [CNT_W-1:0]  UsedMax    = CNT_W'((1 << USED_W) - 1);

  // Input item opcodes.
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_START  = 2'd2,
    MODE_STOP   = 2'd3
  } mode_e;

  // Emission causes.
  localparam logic CAUSE_FIRST = 1'b0;
  localparam logic CAUSE_TIMER = 1'b1;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Map a quotient onto the 12-bit output field.
  function automatic logic [OUT_W-1:0] to_out(logic [SUM_W-1:0] q);
    logic [31:0] wide;
    wide = 32'(q);
    return wide[OUT_W-1:0];
  endfunction

  // Saturate the slot count to the samples_used field.
  function automatic logic [USED_W-1:0] sat_used(logic [CNT_W-1:0] n);
    logic [31:0] wide;
    wide = (n > UsedMax) ? 32'(UsedMax) : 32'(n);
    return wide[USED_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/swa_divider.sv]
// Restoring serial divider, one quotient bit per cycle, for the window averager.
`default_nettype none

module swa_divider import swa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output div_stat_t             stat_o,
  output logic      [SUM_W-1:0] quotient_o
);

  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [CNT_W:0]    trial;
  logic              fits;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DCNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? CNT_W'(trial - {1'b0, divisor_i}) : CNT_W'(trial);
      dvd_d = {dvd_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

`default_nettype wire

[hdl/stylus_window_averager.sv]
// Top level of the stylus window averager: ring of samples, timer, slot walk and output register.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o    | mode_i, pos_x_i, pos_y_i
//   out     | output    | out_valid_o / out_ready_i  | avg_x_o, avg_y_o, samples_used_o, cause_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (window_ms)
//
// Requests that start no slot walk leave the sequencer idle and ready. A first sample or an expiring tick
// starts a walk over every slot, then an x and a y divider pass, each a load, SUM_W steps and a done
// strobe, and then the output register load; with no young slot the walk ends in idle with no result.
// Reset clears all control state at once; slots are gated by valid bits, so no clearing pass.
// A result waits in the output register while out_ready_i is low and requests keep being
// taken; a later result then waits in its final state until the register frees up.
`default_nettype none

module stylus_window_averager import swa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input requests.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [11:0]       pos_x_i,
  input  wire logic [11:0]       pos_y_i,
  // Results.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [OUT_W-1:0]       avg_x_o,
  output logic [OUT_W-1:0]       avg_y_o,
  output logic [USED_W-1:0]      samples_used_o,
  output logic                   cause_o,
  // Configuration write.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [WIN_W-1:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_DIV_X = 5'b00100,
    ST_DIV_Y = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;

  logic [WIN_W-1:0]  window_q;
  logic [COORD_BITS-1:0] slot_x_q [RING_SLOTS];
  logic [COORD_BITS-1:0] slot_y_q [RING_SLOTS];
  logic [AGE_W-1:0]  slot_age_q [RING_SLOTS];
  logic [RING_SLOTS-1:0] slot_valid_q;
  logic [IDX_W-1:0]  write_slot_q;
  logic              first_pending_q;
  logic              timer_running_q;
  logic [WIN_W-1:0]  timer_left_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              cause_q, cause_d;
  logic [SUM_W-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic              div_start_q, div_start_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  avg_x_q, avg_y_q;
  logic [USED_W-1:0] used_q;
  logic              out_cause_q;
  logic              out_load;

  logic              in_accept;
  logic              is_sample, is_tick, is_start, is_stop;
  logic              expire;
  logic              hit;
  logic              last_idx;
  logic [CNT_W-1:0]  n_next;
  logic [31:0]       px_wide, py_wide;

  div_stat_t         div_stat;
  logic [SUM_W-1:0]  div_quot;

  // Request decode.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    is_sample = 1'b0;
    is_tick   = 1'b0;
    is_start  = 1'b0;
    is_stop   = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_SAMPLE: is_sample = 1'b1;
      MODE_TICK:   is_tick   = 1'b1;
      MODE_START:  is_start  = 1'b1;
      MODE_STOP:   is_stop   = 1'b1;
      default:     is_stop   = 1'b1;
    endcase
  end

  assign expire  = is_tick && timer_running_q && (timer_left_q <= WIN_W'(1));
  assign px_wide = 32'(pos_x_i);
  assign py_wide = 32'(pos_y_i);

  // Window register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  // Ring payload: a sample fills one slot, a tick ages every slot that is not yet at AgeMax.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      if (in_accept && is_sample && (write_slot_q == IDX_W'(i))) begin
        slot_x_q[i]   <= px_wide[COORD_BITS-1:0];
        slot_y_q[i]   <= py_wide[COORD_BITS-1:0];
        slot_age_q[i] <= '0;
      end else if (in_accept && is_tick && (slot_age_q[i] != AgeMax)) begin
        slot_age_q[i] <= slot_age_q[i] + AGE_W'(1);
      end
    end
  end

  // Ring control, first-sample flag and timer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q    <= '0;
      write_slot_q    <= '0;
      first_pending_q <= 1'b1;
      timer_running_q <= 1'b0;
      timer_left_q    <= '0;
    end else if (in_accept) begin
      if (is_sample) begin
        slot_valid_q[write_slot_q] <= 1'b1;
        write_slot_q <= (write_slot_q == IDX_W'(RING_SLOTS - 1)) ? '0
                                                                 : write_slot_q + IDX_W'(1);
        first_pending_q <= 1'b0;
      end
      if (is_tick && timer_running_q) begin
        timer_left_q <= expire ? window_q : timer_left_q - WIN_W'(1);
      end
      if (is_start) begin
        timer_running_q <= 1'b1;
        timer_left_q    <= window_q;
      end
      if (is_stop) begin
        timer_running_q <= 1'b0;
        first_pending_q <= 1'b1;
      end
    end
  end

  // Slot walk: one slot is checked and accumulated per cycle.
  assign hit      = slot_valid_q[idx_q] && (32'(slot_age_q[idx_q]) < 32'(window_q));
  assign last_idx = (idx_q == IDX_W'(RING_SLOTS - 1));
  assign n_next   = n_q + (hit ? CNT_W'(1) : CNT_W'(0));
  assign out_load = !out_valid_q || out_ready_i;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    n_d         = n_q;
    cause_d     = cause_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    div_start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && ((is_sample && first_pending_q) || expire)) begin
          state_d = ST_SUM;
          idx_d   = '0;
          sx_d    = '0;
          sy_d    = '0;
          n_d     = '0;
          cause_d = is_sample ? CAUSE_FIRST : CAUSE_TIMER;
        end
      end
      ST_SUM: begin
        if (hit) begin
          sx_d = sx_q + SUM_W'(slot_x_q[idx_q]);
          sy_d = sy_q + SUM_W'(slot_y_q[idx_q]);
        end
        n_d   = n_next;
        idx_d = idx_q + IDX_W'(1);
        if (last_idx) begin
          if (n_next == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d     = ST_DIV_X;
            div_start_d = 1'b1;
          end
        end
      end
      ST_DIV_X: begin
        if (div_stat.done) begin
          qx_d        = div_quot;
          state_d     = ST_DIV_Y;
          div_start_d = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (div_stat.done) begin
          qy_d    = div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    cause_q <= cause_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
  end

  // Shared divider: x sum first, then y sum, both by the count of slots inside the window.
  swa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ((state_q == ST_DIV_Y) ? sy_q : sx_q),
    .divisor_i  (n_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_load) begin
      avg_x_q     <= to_out(qx_q);
      avg_y_q     <= to_out(qy_q);
      used_q      <= sat_used(n_q);
      out_cause_q <= cause_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign avg_x_o        = avg_x_q;
  assign avg_y_o        = avg_y_q;
  assign samples_used_o = used_q;
  assign cause_o        = out_cause_q;

  // A result never reports an empty average.
  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_used_o != '0))
    else $error("result with zero samples");

  // The divider only runs while the sequencer waits on it.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) || (state_q == ST_SUM) || (state_q == ST_DONE)) |-> !div_stat.busy)
    else $error("divider busy outside a divide phase");

  // An expiring tick reloads the countdown from the window.
  a_timer_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && expire) |=> (timer_left_q == $past(window_q)))
    else $error("timer not reloaded on expiry");

  // An expiring tick always starts a slot walk.
  a_expire_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && expire) |=> (state_q == ST_SUM) && (idx_q == '0))
    else $error("expiry did not start the slot walk");

endmodule

`default_nettype wire
